// File: hdl/isaac_pkg.sv
package isaac_pkg;

  localparam int unsigned LOG_SIZE = 8;
  localparam int unsigned SIZE     = 1 << LOG_SIZE;
  localparam int unsigned AW       = LOG_SIZE;
  localparam int unsigned WLW      = LOG_SIZE + 1;

  localparam logic [31:0]   GOLDEN   = 32'h9e37_79b9;
  localparam logic [AW-1:0] HALF_OFS = AW'(SIZE >> 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(SIZE - 1);

  typedef enum logic [1:0] {
    CMD_SEED = 2'd0,
    CMD_INIT = 2'd1,
    CMD_DRAW = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  idx;
    logic [31:0] value;
    logic        use_seed;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

endpackage

// File: hdl/isaac_front.sv
module isaac_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            in_cmd_i,
  input  logic [7:0]            in_idx_i,
  input  logic [31:0]           in_value_i,
  input  logic                  in_use_seed_i,
  input  logic                  hold_i,
  output isaac_pkg::queue_out_t q_o,
  input  logic                  pop_i
);

  isaac_pkg::item_t ent_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             push, known;

  // unused command code is dropped here
  assign known      = (in_cmd_i == isaac_pkg::CMD_SEED) || (in_cmd_i == isaac_pkg::CMD_INIT) ||
                      (in_cmd_i == isaac_pkg::CMD_DRAW);
  assign in_ready_o = (cnt_q != 2'd2) && !hold_i;
  assign push       = in_valid_i && in_ready_o && known;

  assign q_o.valid = (cnt_q != 2'd0);
  assign q_o.item  = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q].cmd      <= isaac_pkg::cmd_e'(in_cmd_i);
      ent_q[wr_q].idx      <= in_idx_i;
      ent_q[wr_q].value    <= in_value_i;
      ent_q[wr_q].use_seed <= in_use_seed_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

endmodule

// File: hdl/isaac_back.sv
module isaac_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  isaac_pkg::queue_out_t q_i,
  output logic                  pop_o,
  output logic                  clearing_o,
  output logic                  out_valid_o,
  output logic [31:0]           out_word_o,
  input  logic                  out_ready_i
);

  localparam int unsigned AW = isaac_pkg::AW;

  typedef logic [7:0][31:0] mix_t;

  typedef enum logic [13:0] {
    ST_CLEAR = 14'b00000000000001,
    ST_IDLE  = 14'b00000000000010,
    ST_MIX   = 14'b00000000000100,
    ST_FRD   = 14'b00000000001000,
    ST_FADD  = 14'b00000000010000,
    ST_FWR   = 14'b00000000100000,
    ST_R0    = 14'b00000001000000,
    ST_R1    = 14'b00000010000000,
    ST_R2    = 14'b00000100000000,
    ST_R3    = 14'b00001000000000,
    ST_R4    = 14'b00010000000000,
    ST_R5    = 14'b00100000000000,
    ST_DRD   = 14'b01000000000000,
    ST_DOUT  = 14'b10000000000000
  } state_e;

  // one line of the eight-word scramble
  function automatic mix_t mix_line(mix_t w, logic [2:0] s);
    mix_t        t;
    logic [31:0] sh, n;
    logic [2:0]  s1, s2, s3;
    t  = w;
    s1 = s + 3'd1;
    s2 = s + 3'd2;
    s3 = s + 3'd3;
    case (s)
      3'd0:    sh = t[s1] << 11;
      3'd1:    sh = t[s1] >> 2;
      3'd2:    sh = t[s1] << 8;
      3'd3:    sh = t[s1] >> 16;
      3'd4:    sh = t[s1] << 10;
      3'd5:    sh = t[s1] >> 4;
      3'd6:    sh = t[s1] << 8;
      default: sh = t[s1] >> 9;
    endcase
    n     = t[s] ^ sh;
    t[s]  = n;
    t[s3] = t[s3] + n;
    t[s1] = t[s1] + t[s2];
    return t;
  endfunction

  logic [31:0] sm_mem [isaac_pkg::SIZE];
  logic [31:0] rb_mem [isaac_pkg::SIZE];
  logic [31:0] sm_rd_q, rb_rd_q;

  logic          sm_we, sm_re, rb_we, rb_re;
  logic [AW-1:0] sm_wa, sm_ra, rb_wa, rb_ra;
  logic [31:0]   sm_wd, rb_wd;

  state_e        state_q, state_d;
  logic [31:0]   a_q, a_d, b_q, b_d, c_q, c_d, x_q, x_d, y_q, y_d;
  mix_t          mix_q, mix_d;
  logic [AW-1:0] i_q, i_d;
  logic [2:0]    line_q, line_d;
  logic [1:0]    rnd_q, rnd_d;
  logic          fill_q, fill_d, pass_q, pass_d, seeded_q, seeded_d, pend_q, pend_d;
  logic [isaac_pkg::WLW-1:0] wl_q, wl_d;
  logic          ov_q, ov_d;
  logic [31:0]   ow_q, ow_d;

  logic [31:0]   mv, y_new, src_rd;
  logic [2:0]    k;
  logic          use_rb;

  assign k      = i_q[2:0];
  assign use_rb = seeded_q && !pass_q;
  assign src_rd = use_rb ? rb_rd_q : sm_rd_q;

  always_comb begin
    case (i_q[1:0])
      2'd0:    mv = a_q << 13;
      2'd1:    mv = a_q >> 6;
      2'd2:    mv = a_q << 2;
      default: mv = a_q >> 16;
    endcase
  end

  assign y_new = sm_rd_q + a_q + b_q;

  always_comb begin
    state_d  = state_q;
    a_d = a_q; b_d = b_q; c_d = c_q; x_d = x_q; y_d = y_q;
    mix_d    = mix_q;
    i_d      = i_q;
    line_d   = line_q;
    rnd_d    = rnd_q;
    fill_d   = fill_q;
    pass_d   = pass_q;
    seeded_d = seeded_q;
    pend_d   = pend_q;
    wl_d     = wl_q;
    ov_d     = ov_q && !out_ready_i;
    ow_d     = ow_q;
    pop_o    = 1'b0;
    sm_we = 1'b0; sm_re = 1'b0; rb_we = 1'b0; rb_re = 1'b0;
    sm_wa = i_q;  sm_ra = i_q;  rb_wa = i_q;  rb_ra = i_q;
    sm_wd = '0;   rb_wd = '0;

    case (state_q)
      ST_CLEAR: begin
        sm_we = 1'b1;
        rb_we = 1'b1;
        i_d   = i_q + 1'b1;
        if (i_q == isaac_pkg::LAST_IDX) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_i.valid) begin
          pop_o = 1'b1;
          case (q_i.item.cmd)
            isaac_pkg::CMD_SEED: begin
              rb_we = 1'b1;
              rb_wa = q_i.item.idx[AW-1:0];
              rb_wd = q_i.item.value;
            end
            isaac_pkg::CMD_INIT: begin
              a_d = '0; b_d = '0; c_d = '0;
              for (int j = 0; j < 8; j++) mix_d[j] = isaac_pkg::GOLDEN;
              line_d   = '0;
              rnd_d    = '0;
              fill_d   = 1'b0;
              seeded_d = q_i.item.use_seed;
              pend_d   = 1'b0;
              state_d  = ST_MIX;
            end
            isaac_pkg::CMD_DRAW: begin
              if (wl_q == '0) begin
                pend_d  = 1'b1;
                c_d     = c_q + 32'd1;
                b_d     = b_q + c_q + 32'd1;
                i_d     = '0;
                state_d = ST_R0;
              end else begin
                state_d = ST_DRD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MIX: begin
        mix_d  = mix_line(mix_q, line_q);
        line_d = line_q + 3'd1;
        if (line_q == 3'd7) begin
          if (fill_q) begin
            state_d = ST_FWR;
          end else begin
            rnd_d = rnd_q + 2'd1;
            if (rnd_q == 2'd3) begin
              fill_d  = 1'b1;
              pass_d  = 1'b0;
              i_d     = '0;
              state_d = seeded_q ? ST_FRD : ST_MIX;
            end
          end
        end
      end
      ST_FRD: begin
        sm_re   = !use_rb;
        rb_re   = use_rb;
        state_d = ST_FADD;
      end
      ST_FADD: begin
        mix_d[k] = mix_q[k] + src_rd;
        i_d      = i_q + 1'b1;
        if (k == 3'd7) begin
          i_d     = i_q - AW'(7);
          state_d = ST_MIX;
        end else begin
          state_d = ST_FRD;
        end
      end
      ST_FWR: begin
        sm_we = 1'b1;
        sm_wd = mix_q[k];
        i_d   = i_q + 1'b1;
        if (k == 3'd7) begin
          if (i_q == isaac_pkg::LAST_IDX) begin
            if (seeded_q && !pass_q) begin
              pass_d  = 1'b1;
              state_d = ST_FRD;
            end else begin
              c_d     = c_q + 32'd1;
              b_d     = b_q + c_q + 32'd1;
              state_d = ST_R0;
            end
          end else begin
            state_d = seeded_q ? ST_FRD : ST_MIX;
          end
        end
      end
      ST_R0: begin
        sm_re   = 1'b1;
        state_d = ST_R1;
      end
      ST_R1: begin
        x_d     = sm_rd_q;
        sm_re   = 1'b1;
        sm_ra   = i_q + isaac_pkg::HALF_OFS;
        state_d = ST_R2;
      end
      ST_R2: begin
        a_d     = (a_q ^ mv) + sm_rd_q;
        sm_re   = 1'b1;
        sm_ra   = x_q[AW+1:2];
        state_d = ST_R3;
      end
      ST_R3: begin
        y_d     = y_new;
        sm_we   = 1'b1;
        sm_wd   = y_new;
        state_d = ST_R4;
      end
      ST_R4: begin
        sm_re   = 1'b1;
        sm_ra   = y_q[2*AW+1 -: AW];
        state_d = ST_R5;
      end
      ST_R5: begin
        b_d   = sm_rd_q + x_q;
        rb_we = 1'b1;
        rb_wd = sm_rd_q + x_q;
        i_d   = i_q + 1'b1;
        if (i_q == isaac_pkg::LAST_IDX) begin
          wl_d    = isaac_pkg::WLW'(isaac_pkg::SIZE);
          state_d = pend_q ? ST_DRD : ST_IDLE;
        end else begin
          state_d = ST_R0;
        end
      end
      ST_DRD: begin
        pend_d  = 1'b0;
        wl_d    = wl_q - 1'b1;
        rb_re   = 1'b1;
        rb_ra   = wl_d[AW-1:0];
        state_d = ST_DOUT;
      end
      ST_DOUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ow_d    = rb_rd_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (sm_we) sm_mem[sm_wa] <= sm_wd;
    if (sm_re) sm_rd_q <= sm_mem[sm_ra];
    if (rb_we) rb_mem[rb_wa] <= rb_wd;
    if (rb_re) rb_rd_q <= rb_mem[rb_ra];
    x_q  <= x_d;
    y_q  <= y_d;
    ow_q <= ow_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      a_q      <= '0;
      b_q      <= '0;
      c_q      <= '0;
      mix_q    <= '0;
      i_q      <= '0;
      line_q   <= '0;
      rnd_q    <= '0;
      fill_q   <= 1'b0;
      pass_q   <= 1'b0;
      seeded_q <= 1'b0;
      pend_q   <= 1'b0;
      wl_q     <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      a_q      <= a_d;
      b_q      <= b_d;
      c_q      <= c_d;
      mix_q    <= mix_d;
      i_q      <= i_d;
      line_q   <= line_d;
      rnd_q    <= rnd_d;
      fill_q   <= fill_d;
      pass_q   <= pass_d;
      seeded_q <= seeded_d;
      pend_q   <= pend_d;
      wl_q     <= wl_d;
      ov_q     <= ov_d;
    end
  end

  assign clearing_o  = (state_q == ST_CLEAR);
  assign out_valid_o = ov_q;
  assign out_word_o  = ow_q;

endmodule

// File: hdl/isaac_random_generator.sv
// Draw: a transfer is queued, popped, read from the result buffer, loaded into the output
// register, held off while the last word is unread; one item ends before the next pops.
// A draw that finds the 256-word buffer used up refills it first. Init: scramble rounds,
// a pass that scrambles and writes 8-word groups (seeded: two passes, adding seed, then
// state words), then a refill. Unused command code is dropped at the input. Reset: rst_ni
// asynchronous, active low; a clearing pass then zeroes both memories, s_axis_tready low.
module isaac_random_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // seed_index[7:0], seed_value[39:8]
  input  logic [2:0]  s_axis_tuser,  // cmd[1:0], use_seed[2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // random_word[31:0]
);

  isaac_pkg::queue_out_t q;
  logic                  pop;
  logic                  clearing;

  // front: accepts transfers, drops unused codes, two-entry queue
  isaac_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_cmd_i     (s_axis_tuser[1:0]),
    .in_idx_i     (s_axis_tdata[7:0]),
    .in_value_i   (s_axis_tdata[39:8]),
    .in_use_seed_i(s_axis_tuser[2]),
    .hold_i       (clearing),
    .q_o          (q),
    .pop_i        (pop)
  );

  // back: sequencer over state memory and result buffer, output register
  isaac_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_i        (q),
    .pop_o      (pop),
    .clearing_o (clearing),
    .out_valid_o(m_axis_tvalid),
    .out_word_o (m_axis_tdata),
    .out_ready_i(m_axis_tready)
  );

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> q.valid)
    else $error("pop from empty queue");
  a_clear_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s_axis_tready)
    else $error("input taken during clearing pass");
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> (!m_axis_tvalid && !pop))
    else $error("activity during clearing pass");

endmodule

// File: tb/isaac_random_generator_tb.sv
`timescale 1ns / 1ps

module isaac_random_generator_tb;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // seed_index[7:0], seed_value[39:8]
  logic [2:0]  s_axis_tuser = '0;   // cmd[1:0], use_seed[2]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // random_word[31:0]

  always #4 clk_i = ~clk_i;

  isaac_random_generator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Generator image kept by the testbench
  logic [31:0] gen_mem [isaac_pkg::SIZE];
  logic [31:0] gen_rsl [isaac_pkg::SIZE];
  logic [31:0] gen_a, gen_b, gen_c;
  logic [31:0] gen_mix [8];
  logic [8:0]  gen_left;

  logic [31:0] words_due [$];
  bit          failed = 1'b0;
  bit          hold_off = 1'b0;   // forces the receiver to stall
  int          hold_cycles = 0;
  int unsigned cycle_cnt = 0;

  function automatic void scramble_words();
    gen_mix[0] ^= gen_mix[1] << 11; gen_mix[3] += gen_mix[0]; gen_mix[1] += gen_mix[2];
    gen_mix[1] ^= gen_mix[2] >> 2;  gen_mix[4] += gen_mix[1]; gen_mix[2] += gen_mix[3];
    gen_mix[2] ^= gen_mix[3] << 8;  gen_mix[5] += gen_mix[2]; gen_mix[3] += gen_mix[4];
    gen_mix[3] ^= gen_mix[4] >> 16; gen_mix[6] += gen_mix[3]; gen_mix[4] += gen_mix[5];
    gen_mix[4] ^= gen_mix[5] << 10; gen_mix[7] += gen_mix[4]; gen_mix[5] += gen_mix[6];
    gen_mix[5] ^= gen_mix[6] >> 4;  gen_mix[0] += gen_mix[5]; gen_mix[6] += gen_mix[7];
    gen_mix[6] ^= gen_mix[7] << 8;  gen_mix[1] += gen_mix[6]; gen_mix[7] += gen_mix[0];
    gen_mix[7] ^= gen_mix[0] >> 9;  gen_mix[2] += gen_mix[7]; gen_mix[0] += gen_mix[1];
  endfunction

  function automatic void refill_buffer();
    logic [31:0] a, b, x, y, mv;
    a = gen_a;
    gen_c += 32'd1;
    b = gen_b + gen_c;
    for (int i = 0; i < isaac_pkg::SIZE; i++) begin
      x = gen_mem[i];
      case (i % 4)
        0: mv = a << 13;
        1: mv = a >> 6;
        2: mv = a << 2;
        default: mv = a >> 16;
      endcase
      a = (a ^ mv) + gen_mem[(i + isaac_pkg::SIZE / 2) % isaac_pkg::SIZE];
      y = gen_mem[(x >> 2) % isaac_pkg::SIZE] + a + b;
      gen_mem[i] = y;
      b = gen_mem[(y >> (isaac_pkg::LOG_SIZE + 2)) % isaac_pkg::SIZE] + x;
      gen_rsl[i] = b;
    end
    gen_a = a;
    gen_b = b;
  endfunction

  // one pass over the state memory; src_rsl picks the seed source
  function automatic void fill_state(bit add, bit src_rsl);
    for (int i = 0; i < isaac_pkg::SIZE; i += 8) begin
      if (add)
        for (int k = 0; k < 8; k++)
          gen_mix[k] += src_rsl ? gen_rsl[(i + k) % isaac_pkg::SIZE]
                                : gen_mem[(i + k) % isaac_pkg::SIZE];
      scramble_words();
      for (int k = 0; k < 8; k++) gen_mem[(i + k) % isaac_pkg::SIZE] = gen_mix[k];
    end
  endfunction

  function automatic void predict_item(logic [1:0] cmd, logic [7:0] idx,
                                       logic [31:0] value, logic use_seed);
    case (cmd)
      isaac_pkg::CMD_SEED: gen_rsl[idx % isaac_pkg::SIZE] = value;
      isaac_pkg::CMD_INIT: begin
        gen_a = '0; gen_b = '0; gen_c = '0;
        for (int k = 0; k < 8; k++) gen_mix[k] = isaac_pkg::GOLDEN;
        for (int k = 0; k < 4; k++) scramble_words();
        if (use_seed) begin
          fill_state(1'b1, 1'b1);
          fill_state(1'b1, 1'b0);
        end else begin
          fill_state(1'b0, 1'b0);
        end
        refill_buffer();
        gen_left = 9'(isaac_pkg::SIZE);
      end
      isaac_pkg::CMD_DRAW: begin
        if (gen_left == 0) begin
          refill_buffer();
          gen_left = 9'(isaac_pkg::SIZE);
        end
        gen_left = gen_left - 9'd1;
        words_due.push_back(gen_rsl[gen_left % isaac_pkg::SIZE]);
      end
      default: ;  // unused code: dropped
    endcase
  endfunction

  // valid stays high after a transfer; the next call replaces or drops it, drain_words drops it
  task automatic send_item(logic [1:0] cmd, logic [7:0] idx, logic [31:0] value,
                           logic use_seed, bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {value, idx};
    s_axis_tuser  <= {use_seed, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_item(cmd, idx, value, use_seed);
  endtask

  task automatic drain_words();
    s_axis_tvalid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);   // seed and init items leave no result to wait for
  endtask

  // receiver: random stalls per word, or a forced hold-off
  always @(posedge clk_i) begin
    if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (m_axis_tready && m_axis_tvalid) begin
      hold_cycles <= $urandom_range(0, 12) * ($urandom_range(0, 3) != 0);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker: sampled at the edge where the transfer happens
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (words_due.size() == 0) begin
        $error("random_word: no word expected, got %h", m_axis_tdata);
        failed = 1'b1;
      end else begin
        if (m_axis_tdata !== words_due[0]) begin
          $error("random_word: expected %h, actual %h", words_due[0], m_axis_tdata);
          failed = 1'b1;
        end
        void'(words_due.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_unseeded_start();
    // draw before any init runs a refill on the zeroed state
    send_item(isaac_pkg::CMD_DRAW, 8'h00, 32'h0, 1'b0);
    send_item(isaac_pkg::CMD_DRAW, 8'hff, 32'hffff_ffff, 1'b1);
    send_item(CMD_UNUSED, 8'h5a, 32'hdead_beef, 1'b1);
    send_item(isaac_pkg::CMD_INIT, 8'h00, 32'h0, 1'b0);
    for (int i = 0; i < 4; i++)
      send_item(isaac_pkg::CMD_DRAW, 8'($urandom), $urandom, 1'($urandom));
  endtask

  task automatic test_seeded_init();
    send_item(isaac_pkg::CMD_SEED, 8'h00, 32'h0000_0000, 1'b0);
    send_item(isaac_pkg::CMD_SEED, 8'hff, 32'hffff_ffff, 1'b1);
    send_item(isaac_pkg::CMD_SEED, 8'h80, 32'h8000_0001, 1'b0);
    send_item(isaac_pkg::CMD_INIT, 8'hff, 32'hffff_ffff, 1'b1);
    for (int i = 0; i < 4; i++) send_item(isaac_pkg::CMD_DRAW, 8'h00, 32'h0, 1'b0);
    // seed writes after init alter the buffer that draws read
    send_item(isaac_pkg::CMD_SEED, 8'hfb, 32'h1234_5678, 1'b0);
    send_item(isaac_pkg::CMD_DRAW, 8'h00, 32'h0, 1'b0);
    drain_words();   // sender pauses until every word is back
  endtask

  task automatic test_back_pressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 20; i++)
        send_item(isaac_pkg::CMD_DRAW, 8'($urandom), $urandom, 1'b0, 1'b0);
    join
  endtask

  // mix of full seed sets, seeds, inits, unused codes, draw runs that cross refills
  task automatic test_random_runs();
    int sent;
    int r;
    sent = 0;
    while (sent < 500) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          for (int i = 0; i < isaac_pkg::SIZE; i++) begin
            send_item(isaac_pkg::CMD_SEED, 8'(i), $urandom, 1'($urandom),
                      $urandom_range(0, 7) == 0);
          end
          sent += isaac_pkg::SIZE;
        end else begin
          send_item(isaac_pkg::CMD_SEED, 8'($urandom), $urandom, 1'($urandom));
          sent++;
        end
        send_item(isaac_pkg::CMD_INIT, 8'($urandom), $urandom, 1'($urandom));
        sent++;
      end else if (r == 1) begin
        send_item(isaac_pkg::CMD_SEED, 8'($urandom), $urandom, 1'($urandom));
        sent++;
      end else if (r == 2) begin
        send_item(CMD_UNUSED, 8'($urandom), $urandom, 1'($urandom));
        sent++;
      end else begin
        // bursts, some with no gaps, so a refill shows up mid-run
        for (int i = 0; i < 20; i++)
          send_item(isaac_pkg::CMD_DRAW, 8'($urandom), $urandom, 1'($urandom), r > 6);
        sent += 20;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < isaac_pkg::SIZE; i++) begin
      gen_mem[i] = '0;
      gen_rsl[i] = '0;
    end
    for (int k = 0; k < 8; k++) gen_mix[k] = '0;
    gen_a = '0; gen_b = '0; gen_c = '0; gen_left = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_unseeded_start();
    test_seeded_init();
    test_back_pressure();
    test_random_runs();

    drain_words();
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
